/* rtl/srs_pkg.sv */
// Shared types and constants for the sound replay suppressor.
// No dependencies; imported by sound_replay_suppressor_core.
package srs_pkg;

  localparam int SLOTS       = 16;
  localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int SOUND_W     = 16;
  localparam int TICKS_W     = 32;
  localparam int WINDOW_W    = 16;
  localparam int SLOT_USED_W = 4;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(250);

  typedef enum logic [1:0] {
    OUTCOME_PLAYED     = 2'd0,
    OUTCOME_DUPLICATE  = 2'd1,
    OUTCOME_TABLE_FULL = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TRIM,
    ST_SCAN,
    ST_FINISH
  } srs_state_t;

  typedef struct packed {
    logic [SOUND_W-1:0] sound_id;
    logic [TICKS_W-1:0] now_ticks;
  } srs_req_t;

  typedef struct packed {
    logic                   play;
    outcome_t               outcome;
    logic [SLOT_USED_W-1:0] slot_used;
    logic [SOUND_W-1:0]     sound_out;
  } srs_rsp_t;

endpackage

/* rtl/sound_replay_suppressor_core.sv */
// Sound replay suppressor: time-window duplicate suppression table.
// Depends on srs_pkg (types, slot count, outcome codes).
//
// Each request carries a sound id and the current time in ticks. The block keeps a table of
// SLOTS records (sound, start time) plus a count of records in use, and answers every request
// with exactly one response: play (outcome played, with the slot written and the sound id),
// suppressed as a recent duplicate, or dropped because the table is full. A record is expired
// when its start lies below now minus blackout_window (saturating at zero). On a request the
// sequencer first pops expired records off the tail of the used region one per cycle, then walks
// the remaining used records one per cycle through a single shared compare unit (start versus
// limit, stored sound versus requested sound), stopping early on an unexpired match. The lowest
// expired record seen is reused; otherwise a record is appended if room is left.
// Trim and scan together read at most SLOTS records, one record read and compare per cycle, and
// a duplicate match ends the scan early. The next request is taken in the cycle after the
// previous response is registered. req_stall is high while a request is in work. The response
// sits in an output register, so a new request is taken while an earlier response still waits
// on rsp_stall; the finishing step holds until that register is free.
// blackout_window is sampled when a request is accepted; write it only while the block is idle.
module sound_replay_suppressor_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  srs_pkg::srs_req_t                req,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output srs_pkg::srs_rsp_t                rsp,
  input  logic                             cfg_write,
  input  logic [srs_pkg::WINDOW_W-1:0]     cfg_data
);
  import srs_pkg::*;

  // Sequencer and working registers
  srs_state_t          state, state_next;
  logic [SOUND_W-1:0]  cur_sound, cur_sound_next;
  logic [TICKS_W-1:0]  cur_now, cur_now_next;
  logic [TICKS_W-1:0]  limit, limit_next;
  logic [CNT_W-1:0]    used, used_next;
  logic [CNT_W-1:0]    scan_idx, scan_idx_next;
  logic                have_free, have_free_next;
  logic [SLOT_W-1:0]   pick, pick_next;
  logic                hit, hit_next;
  logic [WINDOW_W-1:0] window;

  // Response register
  logic                rsp_valid_next;
  srs_rsp_t            rsp_next;

  // Record table
  logic [SOUND_W-1:0]  slot_sound [SLOTS];
  logic [TICKS_W-1:0]  slot_start [SLOTS];
  logic                wr_en;
  logic [SLOT_W-1:0]   wr_idx;

  // Shared compare unit
  logic [CNT_W-1:0]    used_dec;
  logic [SLOT_W-1:0]   rd_idx;
  logic                rd_expired;
  logic                rd_match;
  logic [TICKS_W-1:0]  window_ext;
  logic                rsp_free;

  assign window_ext = TICKS_W'(window);
  assign used_dec   = used - CNT_W'(1);
  // Trim reads the tail record, scan reads the walking index.
  assign rd_idx     = (state == ST_TRIM) ? used_dec[SLOT_W-1:0] : scan_idx[SLOT_W-1:0];
  assign rd_expired = slot_start[rd_idx] < limit;
  assign rd_match   = slot_sound[rd_idx] == cur_sound;
  // Output register can take a new response this cycle.
  assign rsp_free   = !rsp_valid || !rsp_stall;
  assign req_stall  = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cur_sound_next = cur_sound;
    cur_now_next   = cur_now;
    limit_next     = limit;
    used_next      = used;
    scan_idx_next  = scan_idx;
    have_free_next = have_free;
    pick_next      = pick;
    hit_next       = hit;
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_next       = rsp;
    wr_en          = 1'b0;
    wr_idx         = pick;

    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          // Latch the request and compute the expiry limit, saturating at zero.
          cur_sound_next = req.sound_id;
          cur_now_next   = req.now_ticks;
          limit_next     = (req.now_ticks >= window_ext) ? req.now_ticks - window_ext
                                                         : '0;
          have_free_next = 1'b0;
          hit_next       = 1'b0;
          pick_next      = '0;
          scan_idx_next  = '0;
          state_next     = ST_TRIM;
        end
      end
      ST_TRIM: begin
        // Pop expired records off the tail, one per cycle.
        if (used != '0 && rd_expired) begin
          used_next = used_dec;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_idx == used) begin
          state_next = ST_FINISH;
        end else if (rd_expired) begin
          // Note the lowest expired record for reuse.
          if (!have_free) begin
            have_free_next = 1'b1;
            pick_next      = scan_idx[SLOT_W-1:0];
          end
          scan_idx_next = scan_idx + CNT_W'(1);
        end else if (rd_match) begin
          hit_next   = 1'b1;
          state_next = ST_FINISH;
        end else begin
          scan_idx_next = scan_idx + CNT_W'(1);
        end
      end
      ST_FINISH: begin
        // Hold until the response register is free, then decide and write back.
        if (rsp_free) begin
          rsp_valid_next = 1'b1;
          state_next     = ST_IDLE;
          if (hit) begin
            rsp_next = '{play: 1'b0, outcome: OUTCOME_DUPLICATE, slot_used: '0, sound_out: '0};
          end else if (have_free) begin
            wr_en    = 1'b1;
            wr_idx   = pick;
            rsp_next = '{play: 1'b1, outcome: OUTCOME_PLAYED,
                         slot_used: SLOT_USED_W'(pick), sound_out: cur_sound};
          end else if (used >= CNT_W'(SLOTS)) begin
            rsp_next = '{play: 1'b0, outcome: OUTCOME_TABLE_FULL, slot_used: '0,
                         sound_out: '0};
          end else begin
            // Append a new record at the end of the used region.
            wr_en     = 1'b1;
            wr_idx    = used[SLOT_W-1:0];
            used_next = used + CNT_W'(1);
            rsp_next  = '{play: 1'b1, outcome: OUTCOME_PLAYED,
                          slot_used: SLOT_USED_W'(used[SLOT_W-1:0]), sound_out: cur_sound};
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      rsp_valid <= 1'b0;
      window    <= WINDOW_RESET;
    end else begin
      used      <= used_next;
      rsp_valid <= rsp_valid_next;
      if (cfg_write) begin
        window <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_sound <= cur_sound_next;
    cur_now   <= cur_now_next;
    limit     <= limit_next;
    scan_idx  <= scan_idx_next;
    have_free <= have_free_next;
    pick      <= pick_next;
    hit       <= hit_next;
    rsp       <= rsp_next;
    if (wr_en) begin
      slot_sound[wr_idx] <= cur_sound;
      slot_start[wr_idx] <= cur_now;
    end
  end

endmodule
